### sv/pca_pkg.sv
`timescale 1ns / 1ps
package pca_pkg;
	localparam int W = 36;
	localparam int ACC_W = 68;
	localparam int KINV_BITS = 30;
	localparam logic [KINV_BITS-1:0] KINV = 30'd652032874;
	localparam logic signed [W-1:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [W-1:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [W-1:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic [16:0] TWO_PI_Q14 = 17'd102944;
	localparam logic [16:0] PI_Q14 = 17'd51472;
	localparam logic [17:0] MOD_MAX = 18'd262143;

	typedef logic signed [W-1:0] word_t;

	function automatic word_t atan_q30(input logic [4:0] idx);
		word_t r;
		case (idx)
			5'd0: r = 36'sh03243F6A8;
			5'd1: r = 36'sh01DAC6705;
			5'd2: r = 36'sh00FADBAFC;
			5'd3: r = 36'sh007F56EA6;
			5'd4: r = 36'sh003FEAB76;
			5'd5: r = 36'sh001FFD55B;
			5'd6: r = 36'sh000FFFAAA;
			5'd7: r = 36'sh0007FFF55;
			5'd8: r = 36'sh0003FFFEA;
			5'd9: r = 36'sh0001FFFFD;
			5'd10: r = 36'sh0000FFFFF;
			5'd11: r = 36'sh00007FFFF;
			5'd12: r = 36'sh00003FFFF;
			5'd13: r = 36'sh00001FFFF;
			5'd14: r = 36'sh00000FFFF;
			5'd15: r = 36'sh000007FFF;
			5'd16: r = 36'sh000003FFF;
			5'd17: r = 36'sh000001FFF;
			5'd18: r = 36'sh000000FFF;
			5'd19: r = 36'sh0000007FF;
			5'd20: r = 36'sh0000003FF;
			5'd21: r = 36'sh0000001FF;
			5'd22: r = 36'sh0000000FF;
			5'd23: r = 36'sh00000007F;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage

### sv/pca_if.sv
`timescale 1ns / 1ps
interface pca_req_if;
	logic valid;
	logic ready;
	logic op;
	logic signed [15:0] addend_real;
	logic signed [15:0] addend_imag;
	logic [17:0] load_modulus;
	logic [16:0] load_angle;
	modport source (output valid, op, addend_real, addend_imag, load_modulus, load_angle,
		input ready);
	modport sink (input valid, op, addend_real, addend_imag, load_modulus, load_angle,
		output ready);
endinterface

interface pca_rsp_if;
	logic valid;
	logic ready;
	logic [17:0] modulus;
	logic [16:0] angle;
	logic saturated;
	modport source (output valid, modulus, angle, saturated, input ready);
	modport sink (input valid, modulus, angle, saturated, output ready);
endinterface

### sv/pca_gain.sv
`timescale 1ns / 1ps
module pca_gain import pca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input word_t v,
	output logic done,
	output word_t result
);
	// Shift-and-add multiply by the CORDIC gain correction, one constant bit per
	// cycle, most significant bit first.
	logic signed [ACC_W-1:0] acc_q;
	word_t v_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic signed [ACC_W-1:0] rounded;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= 5'(KINV_BITS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= v;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q <<< 1)
				+ (KINV[cnt_q] ? ACC_W'(v_q) : {ACC_W{1'b0}});
		end
	end

	assign rounded = (acc_q + (ACC_W'(1) <<< 29)) >>> 30;
	assign result = rounded[W-1:0];
	assign done = done_q;
endmodule

### sv/polar_complex_accumulator.sv
`timescale 1ns / 1ps
// Holds one complex value in polar form (modulus Q10.8, angle Q3.14 radians).
// A load transfer stores a new value and answers through the finish state and
// the output register. An add transfer runs a rotation CORDIC on the held value,
// one iteration per cycle, multiplies both parts by the gain correction
// bit-serially, adds the addend, then runs a vectoring CORDIC and a second serial
// gain multiply; both CORDIC passes share one iteration unit. One item is in work
// at a time; a result waits in the output register while the next item is
// accepted. The angle after an add lies in 0..pi.
module polar_complex_accumulator import pca_pkg::*; #(
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	pca_req_if.sink req,
	pca_rsp_if.source rsp
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ROT = 3'd1;
	localparam logic [2:0] ST_GAIN1 = 3'd2;
	localparam logic [2:0] ST_VEC = 3'd3;
	localparam logic [2:0] ST_GAIN2 = 3'd4;
	localparam logic [2:0] ST_FIN = 3'd5;

	logic [2:0] state_q;
	logic [4:0] step_q;
	logic gstart_q;
	word_t x_q, y_q, z_q;
	logic neg_q;
	logic signed [15:0] add_re_q, add_im_q;
	logic [17:0] held_mod_q, res_mod_q;
	logic [16:0] held_ang_q, res_ang_q;
	logic res_sat_q;
	logic out_valid_q;
	logic [17:0] out_mod_q;
	logic [16:0] out_ang_q;
	logic out_sat_q;

	logic gx_done, gy_done;
	word_t gx_res, gy_res;
	word_t dx, dy, at, re, im, zs, zf, z0;
	word_t magw, angw;
	logic last_step, rot_dir, slot_free;
	logic [16:0] la;

	pca_gain u_gain_x (.clk, .arst_n, .start(gstart_q), .v(x_q), .done(gx_done),
		.result(gx_res));
	pca_gain u_gain_y (.clk, .arst_n, .start(gstart_q), .v(y_q), .done(gy_done),
		.result(gy_res));

	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign at = atan_q30(step_q);
	assign last_step = (step_q == 5'(CORDIC_STEPS - 1));
	assign rot_dir = (state_q == ST_ROT) ? (z_q >= 0) : (y_q > 0);
	assign re = gx_res + (W'(add_re_q) <<< 8);
	assign im = gy_res + (W'(add_im_q) <<< 8);
	assign slot_free = !out_valid_q || rsp.ready;
	assign la = (req.load_angle > TWO_PI_Q14) ? req.load_angle - TWO_PI_Q14
		: req.load_angle;

	always_comb begin
		z0 = W'({held_ang_q, 16'd0});
		if (z0 > PI_Q30) begin
			z0 = z0 - TWO_PI_Q30;
		end
	end

	always_comb begin
		magw = (gx_res + W'(128)) >>> 8;
		zs = neg_q ? PI_Q30 - z_q : z_q;
		zf = (zs < 0) ? '0 : zs;
		angw = (zf + W'(32768)) >>> 16;
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			gstart_q <= 1'b0;
			out_valid_q <= 1'b0;
			held_mod_q <= '0;
			held_ang_q <= '0;
		end else begin
			gstart_q <= ((state_q == ST_ROT) || (state_q == ST_VEC)) && last_step;
			if ((state_q == ST_FIN) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						state_q <= req.op ? ST_ROT : ST_FIN;
						step_q <= '0;
					end
				end
				ST_ROT: begin
					step_q <= step_q + 5'd1;
					if (last_step) begin
						state_q <= ST_GAIN1;
					end
				end
				ST_GAIN1: begin
					if (gx_done) begin
						state_q <= ST_VEC;
						step_q <= '0;
					end
				end
				ST_VEC: begin
					step_q <= step_q + 5'd1;
					if (last_step) begin
						state_q <= ST_GAIN2;
					end
				end
				ST_GAIN2: begin
					if (gx_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						held_mod_q <= res_mod_q;
						held_ang_q <= res_ang_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				add_re_q <= req.addend_real;
				add_im_q <= req.addend_imag;
				res_mod_q <= req.load_modulus;
				res_ang_q <= la;
				res_sat_q <= 1'b0;
				y_q <= '0;
				// Fold the held angle into -pi/2..pi/2, flipping the start vector.
				if (z0 > HALF_PI_Q30) begin
					z_q <= z0 - PI_Q30;
					x_q <= -W'({held_mod_q, 8'd0});
				end else if (z0 < -HALF_PI_Q30) begin
					z_q <= z0 + PI_Q30;
					x_q <= -W'({held_mod_q, 8'd0});
				end else begin
					z_q <= z0;
					x_q <= W'({held_mod_q, 8'd0});
				end
			end
			ST_ROT, ST_VEC: begin
				if (rot_dir) begin
					x_q <= (state_q == ST_ROT) ? x_q - dx : x_q + dx;
					y_q <= (state_q == ST_ROT) ? y_q + dy : y_q - dy;
					z_q <= (state_q == ST_ROT) ? z_q - at : z_q + at;
				end else begin
					x_q <= (state_q == ST_ROT) ? x_q + dx : x_q - dx;
					y_q <= (state_q == ST_ROT) ? y_q - dy : y_q + dy;
					z_q <= (state_q == ST_ROT) ? z_q + at : z_q - at;
				end
			end
			ST_GAIN1: begin
				if (gx_done && gy_done) begin
					neg_q <= (re < 0);
					x_q <= (re < 0) ? -re : re;
					y_q <= (im < 0) ? -im : im;
					z_q <= '0;
				end
			end
			ST_GAIN2: begin
				if (gx_done) begin
					if (magw < 0) begin
						res_mod_q <= '0;
						res_sat_q <= 1'b0;
					end else if (magw > W'(MOD_MAX)) begin
						res_mod_q <= MOD_MAX;
						res_sat_q <= 1'b1;
					end else begin
						res_mod_q <= magw[17:0];
						res_sat_q <= 1'b0;
					end
					if (magw <= 0) begin
						res_ang_q <= '0;
					end else if (angw > W'(PI_Q14)) begin
						res_ang_q <= PI_Q14;
					end else begin
						res_ang_q <= angw[16:0];
					end
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					out_mod_q <= res_mod_q;
					out_ang_q <= res_ang_q;
					out_sat_q <= res_sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.valid = out_valid_q;
	assign rsp.modulus = out_mod_q;
	assign rsp.angle = out_ang_q;
	assign rsp.saturated = out_sat_q;
endmodule
